// ----- rtl/wcg_pkg.sv -----
`timescale 1ns / 1ps
package wcg_pkg;

    localparam int MAX_LENGTH    = 4096;
    localparam int FRACTION_BITS = 16;

    localparam int INDEX_W    = 12;
    localparam int KIND_W     = 2;
    localparam int LENGTH_W   = 13;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W = 13;

    // shared divider: 44-bit dividend, 13-bit divisor, 32 quotient bits
    localparam int NUM_W  = 44;
    localparam int DEN_W  = 13;
    localparam int QUOT_W = 32;

    localparam int QUEUE_DEPTH   = 2;
    localparam int HORNER_STEPS  = 8;

    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [31:0] PI_HALF_Q30 = 32'd1686629713;
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [29:0] HAMMING_A   = 30'd579820585;
    localparam logic [29:0] HAMMING_B   = 30'd493921239;
    localparam logic [29:0] HANN_AB     = 30'd536870912;

    localparam logic [KIND_W-1:0] KIND_RECT    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TRI     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HAMMING = 2'd2;
    localparam logic [KIND_W-1:0] KIND_HANN    = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_KIND   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 1'b1;

    // how the back end treats a transaction
    localparam logic [1:0] MODE_ONE  = 2'd0;
    localparam logic [1:0] MODE_ZERO = 2'd1;
    localparam logic [1:0] MODE_TRI  = 2'd2;
    localparam logic [1:0] MODE_COS  = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic        hamming;
        logic [11:0] d;
        logic [11:0] nm1;
    } wcg_item_t;

    // taylor divisors k(k-1) for k = 16, 14, ..., 2
    function automatic logic [7:0] horner_div(input int step);
        logic [7:0] k;
        begin
            case (step)
                0:       k = 8'd240;
                1:       k = 8'd182;
                2:       k = 8'd132;
                3:       k = 8'd90;
                4:       k = 8'd56;
                5:       k = 8'd30;
                6:       k = 8'd12;
                default: k = 8'd2;
            endcase
            return k;
        end
    endfunction

    // floor(2^32 / k(k-1)), quotient estimate is low by at most one
    function automatic logic [31:0] horner_recip(input int step);
        logic [31:0] m;
        begin
            case (step)
                0:       m = 32'd17895697;
                1:       m = 32'd23598721;
                2:       m = 32'd32537631;
                3:       m = 32'd47721858;
                4:       m = 32'd76695844;
                5:       m = 32'd143165576;
                6:       m = 32'd357913941;
                default: m = 32'd2147483648;
            endcase
            return m;
        end
    endfunction

endpackage

// ----- rtl/wcg_front.sv -----
`timescale 1ns / 1ps
module wcg_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [wcg_pkg::INDEX_W-1:0]   sample_index,
    input  logic [wcg_pkg::KIND_W-1:0]    window_kind,
    input  logic [wcg_pkg::LENGTH_W-1:0]  window_length,
    output logic                          push_valid,
    input  logic                          push_ready,
    output wcg_pkg::wcg_item_t            push_item
);
    import wcg_pkg::*;

    logic [16:0]     len_ext;
    logic [16:0]     n_sat;
    logic [12:0]     n;
    logic            oor;
    logic [11:0]     nm1;
    logic [12:0]     two_i;
    logic [12:0]     nm1_w;
    logic [12:0]     d_w;
    wcg_item_t       item_next;
    wcg_item_t       item_reg;
    logic            valid_reg;
    logic            valid_next;
    logic            accept;

    always_comb
    begin
        len_ext = 17'(window_length);
        n_sat   = (len_ext > 17'(MAX_LENGTH)) ? 17'(MAX_LENGTH) : len_ext;
        n       = n_sat[12:0];
        oor     = ({1'b0, sample_index} >= n);
        nm1     = 12'(n - 13'd1);
        two_i   = {sample_index, 1'b0};
        nm1_w   = {1'b0, nm1};
        d_w     = (two_i >= nm1_w) ? (two_i - nm1_w) : (nm1_w - two_i);

        item_next.d       = d_w[11:0];
        item_next.nm1     = nm1;
        item_next.hamming = (window_kind == KIND_HAMMING);
        if (oor)
        begin
            item_next.mode = MODE_ZERO;
        end
        else if (window_kind == KIND_RECT || n == 13'd1)
        begin
            item_next.mode = MODE_ONE;
        end
        else if (window_kind == KIND_TRI)
        begin
            item_next.mode = MODE_TRI;
        end
        else
        begin
            item_next.mode = MODE_COS;
        end
    end

    assign in_ready   = !valid_reg || push_ready;
    assign accept     = in_valid && in_ready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ----- rtl/wcg_queue.sv -----
`timescale 1ns / 1ps
module wcg_queue #(
    parameter int DEPTH = wcg_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  wcg_pkg::wcg_item_t  push_item,
    output logic                pop_valid,
    input  logic                pop_en,
    output wcg_pkg::wcg_item_t  pop_item
);
    import wcg_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wcg_item_t          entry_reg [0:DEPTH-1];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_en && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/wcg_div.sv -----
`timescale 1ns / 1ps
module wcg_div #(
    parameter int TAG_W = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [wcg_pkg::NUM_W-1:0]   in_num,
    input  logic [wcg_pkg::DEN_W-1:0]   in_den,
    input  logic [TAG_W-1:0]            in_tag,
    output logic                        out_valid,
    output logic [wcg_pkg::QUOT_W-1:0]  out_quot,
    output logic [TAG_W-1:0]            out_tag
);
    import wcg_pkg::*;

    // one quotient bit per stage; dividend bits leave the top as quotient bits enter
    logic                valid_reg [1:QUOT_W];
    logic [DEN_W-1:0]    rem_reg   [1:QUOT_W];
    logic [QUOT_W-1:0]   nq_reg    [1:QUOT_W];
    logic [DEN_W-1:0]    den_reg   [1:QUOT_W];
    logic [TAG_W-1:0]    tag_reg   [1:QUOT_W];

    genvar j;
    generate
        for (j = 0; j < QUOT_W; j++)
        begin : g_step
            logic                v_cur;
            logic [DEN_W-1:0]    rem_cur;
            logic [QUOT_W-1:0]   nq_cur;
            logic [DEN_W-1:0]    den_cur;
            logic [TAG_W-1:0]    tag_cur;
            logic [DEN_W:0]      trial;
            logic                ge;
            logic [DEN_W:0]      diff;
            logic [DEN_W-1:0]    rem_next;
            logic [QUOT_W-1:0]   nq_next;

            if (j == 0)
            begin : g_first
                assign v_cur   = in_valid;
                assign rem_cur = DEN_W'(in_num[NUM_W-1:QUOT_W]);
                assign nq_cur  = in_num[QUOT_W-1:0];
                assign den_cur = in_den;
                assign tag_cur = in_tag;
            end
            else
            begin : g_rest
                assign v_cur   = valid_reg[j];
                assign rem_cur = rem_reg[j];
                assign nq_cur  = nq_reg[j];
                assign den_cur = den_reg[j];
                assign tag_cur = tag_reg[j];
            end

            assign trial    = {rem_cur, nq_cur[QUOT_W-1]};
            assign ge       = (trial >= {1'b0, den_cur});
            assign diff     = ge ? (trial - {1'b0, den_cur}) : trial;
            assign rem_next = diff[DEN_W-1:0];
            assign nq_next  = {nq_cur[QUOT_W-2:0], ge};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[j+1] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[j+1] <= v_cur;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j+1] <= rem_next;
                    nq_reg[j+1]  <= nq_next;
                    den_reg[j+1] <= den_cur;
                    tag_reg[j+1] <= tag_cur;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[QUOT_W];
    assign out_quot  = nq_reg[QUOT_W];
    assign out_tag   = tag_reg[QUOT_W];

endmodule

// ----- rtl/wcg_cos.sv -----
`timescale 1ns / 1ps
module wcg_cos #(
    parameter int TAG_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [30:0]       in_r,
    input  logic [TAG_W-1:0]  in_tag,
    output logic              out_valid,
    output logic [30:0]       out_c,
    output logic [TAG_W-1:0]  out_tag
);
    import wcg_pkg::*;

    // three stages per horner step: s*t, reciprocal multiply, correction
    localparam int STAGES = 3 * HORNER_STEPS;

    logic               valid_reg [0:STAGES];
    logic [TAG_W-1:0]   tag_reg   [0:STAGES];
    logic [31:0]        s_reg     [0:STAGES];
    logic [31:0]        x_reg     [0:HORNER_STEPS-1];
    logic [31:0]        q0_reg    [0:HORNER_STEPS-1];
    logic [31:0]        xb_reg    [0:HORNER_STEPS-1];
    logic [30:0]        t_reg     [0:HORNER_STEPS-1];
    logic [61:0]        sq_full;

    assign sq_full = 62'(in_r) * 62'(in_r);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg[0]   <= sq_full[61:30];
            tag_reg[0] <= in_tag;
        end
    end

    genvar k;
    generate
        for (k = 0; k < STAGES; k++)
        begin : g_carry
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k+1] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[k+1] <= valid_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    s_reg[k+1]   <= s_reg[k];
                    tag_reg[k+1] <= tag_reg[k];
                end
            end
        end
    endgenerate

    genvar j;
    generate
        for (j = 0; j < HORNER_STEPS; j++)
        begin : g_horner
            localparam int          BASE = 3 * j;
            localparam logic [7:0]  KDIV = horner_div(j);
            localparam logic [31:0] MREC = horner_recip(j);

            logic [30:0] t_cur;
            logic [62:0] st_prod;
            logic [31:0] x_next;
            logic [63:0] qm_prod;
            logic [31:0] q0_next;
            logic [39:0] qk_prod;
            logic [39:0] rem;
            logic [31:0] p_val;
            logic [30:0] t_next;

            if (j == 0)
            begin : g_first
                assign t_cur = Q30_ONE;
            end
            else
            begin : g_rest
                assign t_cur = t_reg[j-1];
            end

            assign st_prod = 63'(s_reg[BASE]) * 63'(t_cur);
            assign x_next  = st_prod[61:30];
            assign qm_prod = 64'(x_reg[j]) * 64'(MREC);
            assign q0_next = qm_prod[63:32];
            assign qk_prod = 40'(q0_reg[j]) * 40'(KDIV);
            assign rem     = 40'(xb_reg[j]) - qk_prod;
            assign p_val   = q0_reg[j] + 32'(rem >= 40'(KDIV));
            assign t_next  = (p_val > {1'b0, Q30_ONE}) ? '0 : (Q30_ONE - p_val[30:0]);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[j]  <= x_next;
                    q0_reg[j] <= q0_next;
                    xb_reg[j] <= x_reg[j];
                    t_reg[j]  <= t_next;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[STAGES];
    assign out_c     = t_reg[HORNER_STEPS-1];
    assign out_tag   = tag_reg[STAGES];

endmodule

// ----- rtl/wcg_back.sv -----
`timescale 1ns / 1ps
module wcg_back #(
    parameter int FRACTION_BITS = wcg_pkg::FRACTION_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pop_valid,
    output logic                       pop_en,
    input  wcg_pkg::wcg_item_t         pop_item,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [FRACTION_BITS:0]     coefficient,
    output logic                       index_out_of_range
);
    import wcg_pkg::*;

    localparam int COEF_W = FRACTION_BITS + 1;
    localparam int SHIFT  = 30 - FRACTION_BITS;
    localparam logic [COEF_W-1:0] COEF_ONE = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [31:0]       HALF     = (32'd1 << SHIFT) >> 1;

    typedef struct packed {
        logic [1:0]        mode;
        logic              hamming;
        logic              neg;
        logic [COEF_W-1:0] coef;
    } tag_t;

    localparam int TAG_W = $bits(tag_t);

    logic                en;

    // operand stage
    logic [12:0]         tri_den;
    logic [NUM_W-1:0]    num_tri;
    logic [NUM_W-1:0]    cos_prod;
    logic [NUM_W-1:0]    num_cos;
    logic [NUM_W-1:0]    num_next;
    logic [DEN_W-1:0]    den_next;
    tag_t                ptag_next;
    logic                p_valid_reg;
    logic [NUM_W-1:0]    p_num_reg;
    logic [DEN_W-1:0]    p_den_reg;
    tag_t                p_tag_reg;

    logic                d_valid;
    logic [QUOT_W-1:0]   d_quot;
    tag_t                d_tag;

    // angle reduction stage
    logic [31:0]         theta;
    logic                neg;
    logic [31:0]         r_full;
    tag_t                qtag_next;
    logic                q_valid_reg;
    logic [30:0]         q_r_reg;
    tag_t                q_tag_reg;

    logic                c_valid;
    logic [30:0]         c_val;
    tag_t                c_tag;

    // scale stage
    logic [29:0]         b_coef;
    logic [60:0]         bc_prod;
    logic                b_valid_reg;
    logic [29:0]         b_bc_reg;
    tag_t                b_tag_reg;

    // output stage
    logic [29:0]         a_coef;
    logic [30:0]         v;
    logic [31:0]         rnd;
    logic [31:0]         rnd_sh;
    logic [COEF_W-1:0]   coef_cos;
    logic [COEF_W-1:0]   coef_next;
    logic                out_valid_reg;
    logic [COEF_W-1:0]   coef_reg;
    logic                oor_reg;

    assign en     = !out_valid_reg || out_ready;
    assign pop_en = en;

    always_comb
    begin
        tri_den  = {1'b0, pop_item.nm1} + 13'd2;
        num_tri  = (NUM_W'(tri_den - {1'b0, pop_item.d}) << FRACTION_BITS)
                   + NUM_W'(tri_den >> 1);
        cos_prod = NUM_W'(PI_Q30) * NUM_W'(pop_item.d);
        num_cos  = cos_prod + NUM_W'(pop_item.nm1 >> 1);

        ptag_next.mode    = pop_item.mode;
        ptag_next.hamming = pop_item.hamming;
        ptag_next.neg     = 1'b0;
        ptag_next.coef    = '0;

        case (pop_item.mode)
            MODE_TRI:
            begin
                num_next = num_tri;
                den_next = tri_den;
            end
            MODE_COS:
            begin
                num_next = num_cos;
                den_next = {1'b0, pop_item.nm1};
            end
            default:
            begin
                num_next = '0;
                den_next = 13'd1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg <= pop_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_num_reg <= num_next;
            p_den_reg <= den_next;
            p_tag_reg <= ptag_next;
        end
    end

    wcg_div #(
        .TAG_W (TAG_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p_valid_reg),
        .in_num    (p_num_reg),
        .in_den    (p_den_reg),
        .in_tag    (p_tag_reg),
        .out_valid (d_valid),
        .out_quot  (d_quot),
        .out_tag   (d_tag)
    );

    always_comb
    begin
        theta  = (d_quot > PI_Q30) ? PI_Q30 : d_quot;
        neg    = (theta > PI_HALF_Q30);
        r_full = neg ? (PI_Q30 - theta) : theta;

        qtag_next     = d_tag;
        qtag_next.neg = neg;
        case (d_tag.mode)
            MODE_ONE:  qtag_next.coef = COEF_ONE;
            MODE_TRI:  qtag_next.coef = (d_quot > 32'(COEF_ONE)) ? COEF_ONE
                                                                  : COEF_W'(d_quot);
            default:   qtag_next.coef = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            q_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_r_reg   <= r_full[30:0];
            q_tag_reg <= qtag_next;
        end
    end

    wcg_cos #(
        .TAG_W (TAG_W)
    ) u_cos (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (q_valid_reg),
        .in_r      (q_r_reg),
        .in_tag    (q_tag_reg),
        .out_valid (c_valid),
        .out_c     (c_val),
        .out_tag   (c_tag)
    );

    assign b_coef  = c_tag.hamming ? HAMMING_B : HANN_AB;
    assign bc_prod = 61'(b_coef) * 61'(c_val);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= c_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_bc_reg  <= bc_prod[59:30];
            b_tag_reg <= c_tag;
        end
    end

    always_comb
    begin
        a_coef = b_tag_reg.hamming ? HAMMING_A : HANN_AB;
        if (b_tag_reg.neg)
        begin
            v = (b_bc_reg > a_coef) ? '0 : 31'(a_coef - b_bc_reg);
        end
        else
        begin
            v = 31'(a_coef) + 31'(b_bc_reg);
        end
        rnd      = 32'(v) + HALF;
        rnd_sh   = rnd >> SHIFT;
        coef_cos = (rnd_sh > 32'(COEF_ONE)) ? COEF_ONE : COEF_W'(rnd_sh);
        coef_next = (b_tag_reg.mode == MODE_COS) ? coef_cos : b_tag_reg.coef;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            coef_reg <= coef_next;
            oor_reg  <= (b_tag_reg.mode == MODE_ZERO);
        end
    end

    assign out_valid          = out_valid_reg;
    assign coefficient        = coef_reg;
    assign index_out_of_range = oor_reg;

endmodule

// ----- rtl/window_coefficient_generator.sv -----
// throughput: one transaction per cycle unless the output stalls, via the 32-stage divider and 25-stage cosine pipe
// the front end and the back end are parted by a two-entry queue, so the front end takes up
// to three more transactions while the back end waits on the output register
// reset: asynchronous, active low; clears all valid state, kind to rectangular, length to 64
`timescale 1ns / 1ps
module window_coefficient_generator #(
    parameter int FRACTION_BITS = wcg_pkg::FRACTION_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [wcg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wcg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [wcg_pkg::INDEX_W-1:0]     sample_index,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [FRACTION_BITS:0]          coefficient,
    output logic                            index_out_of_range
);
    import wcg_pkg::*;

    logic [KIND_W-1:0]   kind_reg;
    logic [LENGTH_W-1:0] length_reg;
    logic                push_valid;
    logic                push_ready;
    wcg_item_t           push_item;
    logic                pop_valid;
    logic                pop_en;
    wcg_item_t           pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg   <= KIND_RECT;
            length_reg <= 13'd64;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_WINDOW_KIND:   kind_reg   <= cfg_data[KIND_W-1:0];
                REG_WINDOW_LENGTH: length_reg <= cfg_data[LENGTH_W-1:0];
                default:           kind_reg   <= kind_reg;
            endcase
        end
    end

    wcg_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample_index  (sample_index),
        .window_kind   (kind_reg),
        .window_length (length_reg),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    wcg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_en     (pop_en),
        .pop_item   (pop_item)
    );

    wcg_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .pop_valid          (pop_valid),
        .pop_en             (pop_en),
        .pop_item           (pop_item),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .coefficient        (coefficient),
        .index_out_of_range (index_out_of_range)
    );

endmodule
